// File: hdl/radix_digit_converter_core_macros.svh
// Assertion macros used by the radix digit converter checker.
`ifndef RADIX_DIGIT_CONVERTER_CORE_MACROS_SVH
`define RADIX_DIGIT_CONVERTER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define RDC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define RDC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/rdc_pkg.sv
// Shared constants and a helper function for the radix digit converter.
`timescale 1ns / 1ps
`default_nettype none

package rdc_pkg;

	// Payload widths
	localparam int VALUE_W = 32;
	localparam int RADIX_W = 5;
	localparam int CHAR_W  = 7;
	localparam int DIGIT_W = 4;

	// Digit stack sizing
	localparam int DIGIT_SLOTS = 32;
	localparam int IDX_W       = $clog2(DIGIT_SLOTS);
	localparam int CNT_W       = $clog2(DIGIT_SLOTS + 1);

	// Divider: one chunk of the dividend per cycle
	localparam int CHUNK_W     = 8;
	localparam int CHUNKS      = VALUE_W / CHUNK_W;
	localparam int CHUNK_CNT_W = $clog2(CHUNKS);

	// Radix limits and reset value
	localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
	localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(16);
	localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);

	// ASCII codes
	localparam logic [CHAR_W-1:0] CHAR_ZERO   = 7'h30;
	localparam logic [CHAR_W-1:0] CHAR_NINE   = 7'h39;
	localparam logic [CHAR_W-1:0] CHAR_A      = 7'h41;
	localparam logic [CHAR_W-1:0] CHAR_F      = 7'h46;
	localparam logic [CHAR_W-1:0] CHAR_ERROR  = 7'h00;
	localparam logic [DIGIT_W-1:0] DECIMAL_TOP = DIGIT_W'(9);
	localparam logic [DIGIT_W-1:0] LETTER_BASE = DIGIT_W'(10);

	// Digit value to ASCII character
	function automatic logic [CHAR_W-1:0] digit_ascii(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] c;
		if (d > DECIMAL_TOP) begin
			c = CHAR_A + CHAR_W'(d - LETTER_BASE);
		end else begin
			c = CHAR_ZERO + CHAR_W'(d);
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// File: hdl/rdc_if.sv
// Valid/ready channel interfaces for the radix digit converter.
`timescale 1ns / 1ps
`default_nettype none

// Input channel: one signed value per transaction
interface rdc_value_if;
	logic                               valid;
	logic                               ready;
	logic signed [rdc_pkg::VALUE_W-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

// Output channel: one character per transaction
interface rdc_digit_if;
	logic                        valid;
	logic                        ready;
	logic [rdc_pkg::CHAR_W-1:0]  digit_char;
	logic                        last_digit;
	logic                        bad_request;

	modport source (output valid, output digit_char, output last_digit, output bad_request,
		input ready);
	modport sink   (input valid, input digit_char, input last_digit, input bad_request,
		output ready);
endinterface

`default_nettype wire

// File: hdl/radix_digit_converter_core.sv
// Radix digit converter: signed value in, ASCII digits of it out, most significant first.
`timescale 1ns / 1ps
`default_nettype none

// Converts a non-negative 32-bit value into digits of the radix held in the
// cfg register (reset 10, legal 2..16) and sends them most significant digit
// first as ASCII '0'-'9' / 'A'-'F', one transaction per digit, with
// last_digit set on the final one. A zero value gives the single digit '0'.
// A negative value or an illegal radix gives one transaction with
// bad_request and last_digit set and digit_char zero, presented the cycle
// after the value is taken. For a legal request every digit needs one full
// division by the radix, done by one shared compare-subtract array that
// consumes 8 dividend bits per cycle; remainders go to a 32-entry digit
// stack, a read state fetches the first entry back, then one digit leaves
// per cycle while the output side keeps taking them. The longest request is
// radix 2 with 31 digits. A new value is taken only once the previous one
// has been fully handed to the output register. The radix may be written
// only while the block is idle.
module radix_digit_converter_core (
	input  wire                             clk,
	input  wire                             arst_n,
	rdc_value_if.sink                       value_chan,
	rdc_digit_if.source                     digit_chan,
	input  wire                             cfg_we,
	input  wire  [rdc_pkg::RADIX_W-1:0]     cfg_wdata
);
	import rdc_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_DIV  = 4'b0010,
		ST_READ = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	state_t                    state_q;
	logic [RADIX_W-1:0]        radix_q;
	logic [VALUE_W-1:0]        div_q;
	logic [DIGIT_W-1:0]        rem_q;
	logic [CHUNK_CNT_W-1:0]    chunk_q;
	logic [CNT_W-1:0]          cnt_q;
	logic [DIGIT_W-1:0]        stack_mem [DIGIT_SLOTS];
	logic [DIGIT_W-1:0]        rd_data_q;

	logic                      out_valid_q;
	logic [CHAR_W-1:0]         char_q;
	logic                      last_q;
	logic                      bad_q;

	logic                      slot_free;
	logic                      accept;
	logic                      req_bad;
	logic [CHUNK_W-1:0]        qbits;
	logic [DIGIT_W-1:0]        rem_next;
	logic [VALUE_W-1:0]        quo_next;
	logic [CNT_W-1:0]          cnt_inc;
	logic                      div_last_chunk;
	logic                      div_done;
	logic                      rd_en;
	logic [IDX_W-1:0]          rd_addr;
	logic [CNT_W-1:0]          cnt_dec;

	// Handshake on the input side
	assign slot_free        = !out_valid_q || digit_chan.ready;
	assign value_chan.ready = (state_q == ST_IDLE) && slot_free;
	assign accept           = value_chan.valid && value_chan.ready;
	assign req_bad          = (radix_q < RADIX_MIN) || (radix_q > RADIX_MAX)
		|| value_chan.value[VALUE_W-1];

	// Shared divider step: top chunk of the dividend against the radix
	always_comb begin
		logic [DIGIT_W:0] t;
		logic [DIGIT_W:0] r;
		r = {1'b0, rem_q};
		qbits = '0;
		for (int i = CHUNK_W - 1; i >= 0; i--) begin
			t = {r[DIGIT_W-1:0], div_q[VALUE_W - CHUNK_W + i]};
			if (t >= {{(DIGIT_W + 1 - RADIX_W){1'b0}}, radix_q}) begin
				t = t - {{(DIGIT_W + 1 - RADIX_W){1'b0}}, radix_q};
				qbits[i] = 1'b1;
			end
			r = t;
		end
		rem_next = r[DIGIT_W-1:0];
	end

	assign quo_next       = {div_q[VALUE_W-CHUNK_W-1:0], qbits};
	assign cnt_inc        = cnt_q + CNT_W'(1);
	assign cnt_dec        = cnt_q - CNT_W'(1);
	assign div_last_chunk = (chunk_q == CHUNK_CNT_W'(CHUNKS - 1));
	assign div_done       = (quo_next == '0) || (cnt_inc == CNT_W'(DIGIT_SLOTS));

	// Stack read port request
	assign rd_addr = cnt_dec[IDX_W-1:0];
	always_comb begin
		unique case (state_q)
			ST_READ: rd_en = 1'b1;
			ST_EMIT: rd_en = slot_free && (cnt_q != '0);
			default: rd_en = 1'b0;
		endcase
	end

	// Digit stack: written during division, read back in reverse
	always_ff @(posedge clk) begin
		if ((state_q == ST_DIV) && div_last_chunk) begin
			stack_mem[cnt_q[IDX_W-1:0]] <= rem_next;
		end
		if (rd_en) begin
			rd_data_q <= stack_mem[rd_addr];
		end
	end

	// Config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (cfg_we) begin
			radix_q <= cfg_wdata;
		end
	end

	// Sequencer and working registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			chunk_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && !req_bad) begin
						state_q <= ST_DIV;
						cnt_q   <= '0;
						chunk_q <= '0;
					end
				end
				ST_DIV: begin
					chunk_q <= chunk_q + CHUNK_CNT_W'(1);
					if (div_last_chunk) begin
						cnt_q <= cnt_inc;
						if (div_done) begin
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: begin
					cnt_q   <= cnt_dec;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (slot_free) begin
						if (cnt_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							cnt_q <= cnt_dec;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Dividend / quotient and running remainder
	always_ff @(posedge clk) begin
		if (accept) begin
			div_q <= {1'b0, value_chan.value[VALUE_W-2:0]};
			rem_q <= '0;
		end else if (state_q == ST_DIV) begin
			div_q <= quo_next;
			rem_q <= div_last_chunk ? '0 : rem_next;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((accept && req_bad) || ((state_q == ST_EMIT) && slot_free)) begin
			out_valid_q <= 1'b1;
		end else if (digit_chan.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && req_bad) begin
			char_q <= CHAR_ERROR;
			last_q <= 1'b1;
			bad_q  <= 1'b1;
		end else if ((state_q == ST_EMIT) && slot_free) begin
			char_q <= digit_ascii(rd_data_q);
			last_q <= (cnt_q == '0);
			bad_q  <= 1'b0;
		end
	end

	assign digit_chan.valid       = out_valid_q;
	assign digit_chan.digit_char  = char_q;
	assign digit_chan.last_digit  = last_q;
	assign digit_chan.bad_request = bad_q;

endmodule

`default_nettype wire

// File: hdl/rdc_checker.sv
// Port-level checker for the radix digit converter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "radix_digit_converter_core_macros.svh"

module rdc_checker (
	input wire                           clk,
	input wire                           arst_n,
	input wire                           value_valid,
	input wire                           value_ready,
	input wire [rdc_pkg::VALUE_W-1:0]    value,
	input wire                           digit_valid,
	input wire                           digit_ready,
	input wire [rdc_pkg::CHAR_W-1:0]     digit_char,
	input wire                           last_digit,
	input wire                           bad_request
);
	import rdc_pkg::*;

	// An error transaction is an empty, final one
	`RDC_ASSERT_NOW(a_err_shape, digit_valid && bad_request, last_digit && (digit_char == CHAR_ERROR), "error transaction must be final with zero char")

	// Normal transactions carry a legal digit character
	`RDC_ASSERT_NOW(a_legal_char, digit_valid && !bad_request, ((digit_char >= CHAR_ZERO) && (digit_char <= CHAR_NINE)) || ((digit_char >= CHAR_A) && (digit_char <= CHAR_F)), "digit character out of range")

	// A negative value is answered by an error on the next cycle
	`RDC_ASSERT_NEXT(a_neg_err, value_valid && value_ready && value[VALUE_W-1], digit_valid && bad_request, "negative value not rejected")

	// A stalled result holds its payload
	`RDC_ASSERT_NEXT(a_out_hold, digit_valid && !digit_ready, digit_valid && $stable(digit_char) && $stable(last_digit) && $stable(bad_request), "stalled output changed")

endmodule

bind radix_digit_converter_core rdc_checker u_rdc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.value_valid (value_chan.valid),
	.value_ready (value_chan.ready),
	.value       (value_chan.value),
	.digit_valid (digit_chan.valid),
	.digit_ready (digit_chan.ready),
	.digit_char  (digit_chan.digit_char),
	.last_digit  (digit_chan.last_digit),
	.bad_request (digit_chan.bad_request)
);

`default_nettype wire

// File: tb/radix_digit_converter_core_tb.sv
// Self-checking testbench for radix_digit_converter_core: directed table, random phases, digit scoreboard.
`timescale 1ns / 1ps

module radix_digit_converter_core_tb;
	import rdc_pkg::*;

	// Idle cycles with no transaction on either channel before the run is declared hung
	localparam int HANG_LIMIT = 3000;
	// Receiver hold-off used to back the block up into its input
	localparam int CHOKE_CYCLES = 400;
	localparam int TEXT_W = 31 * 8;

	typedef enum logic [1:0] {
		CHK_PREDICT,
		CHK_DIGITS,
		CHK_ERROR
	} check_kind_t;

	typedef struct packed {
		logic [RADIX_W-1:0]        radix;
		logic signed [VALUE_W-1:0] value;
		check_kind_t               kind;
		logic [TEXT_W-1:0]         text;
	} stim_row_t;

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              last;
		logic              bad;
	} digit_t;

	// Directed rows: digits typed in where obvious, otherwise the predictor decides
	localparam stim_row_t DIRECTED_ROWS [24] = '{
		'{5'd10, 32'sd0,           CHK_DIGITS,  "0"},
		'{5'd10, 32'sh7FFF_FFFF,   CHK_DIGITS,  "2147483647"},
		'{5'd10, -32'sd1,          CHK_ERROR,   ""},
		'{5'd10, 32'sh8000_0000,   CHK_ERROR,   ""},
		'{5'd10, 32'sd9,           CHK_DIGITS,  "9"},
		'{5'd10, 32'sd10,          CHK_DIGITS,  "10"},
		'{5'd10, 32'sd1000000000,  CHK_DIGITS,  "1000000000"},
		'{5'd16, 32'sh7FFF_FFFF,   CHK_DIGITS,  "7FFFFFFF"},
		'{5'd16, 32'sd255,         CHK_DIGITS,  "FF"},
		'{5'd16, 32'sh00AB_CDEF,   CHK_DIGITS,  "ABCDEF"},
		'{5'd16, 32'sd15,          CHK_DIGITS,  "F"},
		'{5'd2,  32'sh7FFF_FFFF,   CHK_DIGITS,  "1111111111111111111111111111111"},
		'{5'd2,  32'sd0,           CHK_DIGITS,  "0"},
		'{5'd2,  32'sd1,           CHK_DIGITS,  "1"},
		'{5'd0,  32'sd5,           CHK_ERROR,   ""},
		'{5'd1,  32'sd5,           CHK_ERROR,   ""},
		'{5'd17, 32'sd5,           CHK_ERROR,   ""},
		'{5'd31, 32'sd0,           CHK_ERROR,   ""},
		'{5'd31, -32'sd1,          CHK_ERROR,   ""},
		'{5'd3,  32'sh7FFF_FFFF,   CHK_PREDICT, ""},
		'{5'd7,  32'sd123456789,   CHK_PREDICT, ""},
		'{5'd9,  32'sd1,           CHK_PREDICT, ""},
		'{5'd15, 32'sh7FFF_FFFF,   CHK_PREDICT, ""},
		'{5'd8,  32'sh7FFF_FFFF,   CHK_DIGITS,  "17777777777"}
	};

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [RADIX_W-1:0]  cfg_wdata;

	rdc_value_if value_bus ();
	rdc_digit_if digit_bus ();

	// Predictor state and scoreboard
	logic [RADIX_W-1:0]  cur_radix = RADIX_RESET;
	digit_t              digits_due [$];
	check_kind_t         row_kind;
	logic [TEXT_W-1:0]   row_text;
	int                  err_count = 0;
	int                  idle_cycles = 0;
	bit                  hold_off_req = 1'b0;

	radix_digit_converter_core i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.value_chan (value_bus),
		.digit_chan (digit_bus),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata)
	);

	// Clock: 12 ns period
	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("mismatch at %0t ns: %s got %0h want %0h", $time, what, got, want);
		err_count++;
	endtask

	// Digits of one value in the current radix, pushed most significant first
	function automatic void predict_digits(input logic signed [VALUE_W-1:0] v);
		logic [30:0]        quot;
		logic [DIGIT_W-1:0] rems [DIGIT_SLOTS];
		int                 n;
		digit_t             d;
		if (cur_radix < RADIX_MIN || cur_radix > RADIX_MAX || v[VALUE_W-1]) begin
			d = '{CHAR_ERROR, 1'b1, 1'b1};
			digits_due.push_back(d);
			return;
		end
		quot = v[30:0];
		n = 0;
		do begin
			rems[n] = DIGIT_W'(quot % cur_radix);
			quot = quot / cur_radix;
			n++;
		end while (quot != 0 && n < DIGIT_SLOTS);
		for (int i = n - 1; i >= 0; i--) begin
			if (rems[i] > 4'd9) begin
				d.ch = CHAR_A + CHAR_W'(rems[i] - 4'd10);
			end else begin
				d.ch = CHAR_ZERO + CHAR_W'(rems[i]);
			end
			d.last = (i == 0);
			d.bad  = 1'b0;
			digits_due.push_back(d);
		end
	endfunction

	// Sender gap: mostly none, sometimes short, rarely long
	function automatic int pick_gap(input bit calm);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm || r < 55) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 60);
	endfunction

	// Random value: mostly well-formed, with digit-count boundaries and some negatives
	function automatic logic signed [VALUE_W-1:0] draw_value(input logic [RADIX_W-1:0] rdx);
		int unsigned r;
		longint      p;
		int          k;
		logic [31:0] v;
		r = $urandom_range(0, 99);
		if (r < 18) begin
			v = $urandom | 32'h8000_0000;
		end else if (r < 45) begin
			v = $urandom & 32'h7FFF_FFFF;
		end else if (r < 70) begin
			v = $urandom_range(0, 300);
		end else if (r < 90) begin
			p = 1;
			k = $urandom_range(1, 31);
			repeat (k) begin
				if (rdx > 1 && p * rdx <= 64'h7FFF_FFFF) p = p * rdx;
			end
			v = 32'(p - $urandom_range(0, 1));
		end else begin
			v = 32'h7FFF_FFFF - $urandom_range(0, 3);
		end
		return v;
	endfunction

	// Offer one value and hold it until the block takes it
	task automatic offer_value(input logic signed [VALUE_W-1:0] v, input check_kind_t k,
		input logic [TEXT_W-1:0] txt, input int gap);
		if (gap > 0) begin
			value_bus.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		value_bus.valid <= 1'b1;
		value_bus.value <= v;
		row_kind        <= k;
		row_text        <= txt;
		do @(posedge clk); while (!value_bus.ready);
		@(negedge clk);
	endtask

	// Radix write, only once every owed digit has come out
	task automatic write_radix(input logic [RADIX_W-1:0] r);
		value_bus.valid <= 1'b0;
		while (digits_due.size() != 0) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= r;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Stimulus and end of run
	initial begin : stimulus
		logic [RADIX_W-1:0] set_radix;
		logic [RADIX_W-1:0] phase_radix;
		int                 phase_len;
		bit                 calm_tx;
		arst_n          = 1'b0;
		value_bus.valid = 1'b0;
		value_bus.value = '0;
		cfg_we          = 1'b0;
		cfg_wdata       = '0;
		row_kind        = CHK_PREDICT;
		row_text        = '0;
		set_radix       = RADIX_RESET;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (DIRECTED_ROWS[i]) begin
			if (DIRECTED_ROWS[i].radix != set_radix) begin
				set_radix = DIRECTED_ROWS[i].radix;
				write_radix(set_radix);
			end
			offer_value(DIRECTED_ROWS[i].value, DIRECTED_ROWS[i].kind,
				DIRECTED_ROWS[i].text, pick_gap(1'b0));
		end

		// Random phases, each under one radix setting
		for (int ph = 0; ph < 9; ph++) begin
			case (ph)
				0: phase_radix = 5'd2;
				1: phase_radix = 5'd16;
				2: phase_radix = 5'd31;
				3: phase_radix = 5'd10;
				4: phase_radix = 5'd0;
				default: begin
					if ($urandom_range(0, 99) < 85) begin
						phase_radix = RADIX_W'($urandom_range(2, 16));
					end else begin
						phase_radix = RADIX_W'($urandom_range(0, 31));
					end
				end
			endcase
			if (phase_radix != set_radix) begin
				set_radix = phase_radix;
				write_radix(set_radix);
			end
			phase_len = (phase_radix >= RADIX_MIN && phase_radix <= RADIX_MAX) ? 46 : 12;
			calm_tx   = (ph % 3 == 1);
			// back-pressure: receiver stops while values keep coming
			if (ph == 1 || ph == 6) hold_off_req = 1'b1;
			repeat (phase_len) begin
				offer_value(draw_value(phase_radix), CHK_PREDICT, '0, pick_gap(calm_tx));
			end
		end

		value_bus.valid <= 1'b0;
		while (digits_due.size() != 0) @(negedge clk);
		repeat (200) @(negedge clk);
		if (err_count == 0) begin
			$display("radix_digit_converter_core_tb passed");
		end else begin
			$display("radix_digit_converter_core_tb failed");
		end
		$finish;
	end

	// Receiver: random ready, quiet stretches, and the long hold-off on request
	initial begin : receiver
		int          stall_left;
		int          cycle_cnt;
		bit          quiet_rx;
		int unsigned r;
		stall_left      = 0;
		cycle_cnt       = 0;
		quiet_rx        = 1'b0;
		digit_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			cycle_cnt++;
			if (cycle_cnt % 256 == 0) quiet_rx = ($urandom_range(0, 3) == 0);
			if (stall_left > 0) begin
				digit_bus.ready <= 1'b0;
				stall_left--;
			end else if (hold_off_req) begin
				hold_off_req = 1'b0;
				stall_left = CHOKE_CYCLES - 1;
				digit_bus.ready <= 1'b0;
			end else if (quiet_rx) begin
				digit_bus.ready <= 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 70) begin
					digit_bus.ready <= 1'b1;
				end else if (r < 95) begin
					digit_bus.ready <= 1'b0;
					stall_left = $urandom_range(0, 3);
				end else begin
					digit_bus.ready <= 1'b0;
					stall_left = $urandom_range(10, 50);
				end
			end
		end
	end

	// Monitor: radix tracking, prediction on accepted values, digit checking
	always @(posedge clk) begin
		digit_t want;
		digit_t typed;
		if (arst_n) begin
			if (cfg_we) cur_radix = cfg_wdata;

			if (value_bus.valid && value_bus.ready) begin
				case (row_kind)
					CHK_PREDICT: predict_digits(value_bus.value);
					CHK_ERROR: begin
						typed = '{CHAR_ERROR, 1'b1, 1'b1};
						digits_due.push_back(typed);
					end
					default: begin
						// text is right-justified, byte 0 is the least significant digit
						for (int i = 30; i >= 0; i--) begin
							if (row_text[i*8 +: 8] != 8'd0) begin
								typed = '{row_text[i*8 +: CHAR_W], (i == 0), 1'b0};
								digits_due.push_back(typed);
							end
						end
					end
				endcase
			end

			if (digit_bus.valid && digit_bus.ready) begin
				if (digits_due.size() == 0) begin
					report_mismatch("unexpected digit transaction",
						32'(digit_bus.digit_char), 32'd0);
				end else begin
					want = digits_due.pop_front();
					if (digit_bus.digit_char !== want.ch)
						report_mismatch("digit_char", 32'(digit_bus.digit_char),
							32'(want.ch));
					if (digit_bus.last_digit !== want.last)
						report_mismatch("last_digit", 32'(digit_bus.last_digit),
							32'(want.last));
					if (digit_bus.bad_request !== want.bad)
						report_mismatch("bad_request", 32'(digit_bus.bad_request),
							32'(want.bad));
				end
			end
		end
	end

	// Watchdog: too long with no transaction on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((value_bus.valid && value_bus.ready) || (digit_bus.valid && digit_bus.ready)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (idle_cycles >= HANG_LIMIT) begin
				$display("no transaction for %0d cycles", HANG_LIMIT);
				$display("radix_digit_converter_core_tb failed");
				$finish;
			end
		end
	end

endmodule

// File: radix_digit_converter_core.f
+incdir+hdl
hdl/rdc_pkg.sv
hdl/rdc_if.sv
hdl/radix_digit_converter_core.sv
hdl/rdc_checker.sv
tb/radix_digit_converter_core_tb.sv
